// ----- src/usmg_pkg.sv -----
// Package for the UV-sphere mesh unit: fixed-point constants, register codes,
// sine polynomial coefficients. No dependencies.
`timescale 1ns / 1ps
package usmg_pkg;
	localparam int MaxSegmentsDef = 256;
	localparam int AngleBitsDef = 16;
	localparam logic [14:0] OneQ14 = 15'd16384;
	localparam logic [16:0] OneQ16 = 17'd65536;
	localparam logic [2:0] RegSegments = 3'd0;
	localparam logic [2:0] RegRadius = 3'd1;
	localparam logic [2:0] RegFlip = 3'd2;
	localparam logic [2:0] RegUStep = 3'd3;
	localparam logic [2:0] RegVStep = 3'd4;
	localparam logic [2:0] RegColPhase = 3'd5;
	localparam logic [2:0] RegRingPhase = 3'd6;
	localparam logic ActVertex = 1'b0;
	localparam logic [31:0] SinC1 = 32'd1686629713;
	localparam logic [31:0] SinC3 = 32'd693598669;
	localparam logic [31:0] SinC5 = 32'd85569306;
	localparam logic [31:0] SinC7 = 32'd5026995;
	localparam logic [31:0] SinC9 = 32'd172272;

	typedef enum logic [1:0] {
		KIND_FAULT = 2'd0,
		KIND_POLE = 2'd1,
		KIND_RING = 2'd2,
		KIND_TRI = 2'd3
	} kind_t;
endpackage

// ----- src/usmg_sine.sv -----
// Pipelined quarter-wave sine: folds a 16-bit turn angle and evaluates the
// odd degree-9 polynomial in Horner form, at most one product per stage. Uses usmg_pkg.
`timescale 1ns / 1ps
module usmg_sine (
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [15:0] sine
);
	import usmg_pkg::*;

	// Stage 1: fold, x in Q30; x^2 is formed from it and registered in stage 2.
	logic [30:0] x_s1;
	logic        neg_s1;
	logic [14:0] r;
	logic [61:0] xx;
	logic [31:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [30:0] x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic        neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [31:0] t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [63:0] p3, p4, p5, p6, p7;
	logic [33:0] s_s8;
	logic [18:0] rs;

	assign r = angle[14] ? (15'(OneQ14) - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign xx = 62'(x_s1) * 62'(x_s1);

	always_ff @(posedge clk) begin
		x_s1 <= {r, 16'd0};
		neg_s1 <= angle[15];
		x2_s2 <= 32'(xx >> 30);
		x_s2 <= x_s1;
		neg_s2 <= neg_s1;
	end

	assign p3 = 64'(SinC9) * 64'(x2_s2);
	assign p4 = 64'(t_s3) * 64'(x2_s3);
	assign p5 = 64'(t_s4) * 64'(x2_s4);
	assign p6 = 64'(t_s5) * 64'(x2_s5);
	assign p7 = 64'(t_s7) * 64'(x_s7);

	always_ff @(posedge clk) begin
		t_s3 <= SinC7 - 32'(p3 >> 30);
		x2_s3 <= x2_s2;  x_s3 <= x_s2;  neg_s3 <= neg_s2;
		t_s4 <= SinC5 - 32'(p4 >> 30);
		x2_s4 <= x2_s3;  x_s4 <= x_s3;  neg_s4 <= neg_s3;
		t_s5 <= SinC3 - 32'(p5 >> 30);
		x2_s5 <= x2_s4;  x_s5 <= x_s4;  neg_s5 <= neg_s4;
		t_s6 <= SinC1 - 32'(p6 >> 30);
		x_s6 <= x_s5;  neg_s6 <= neg_s5;
		t_s7 <= t_s6;    x_s7 <= x_s6;   neg_s7 <= neg_s6;
		s_s8 <= 34'(p7 >> 30);
		neg_s8 <= neg_s7;
	end

	always_comb begin
		rs = 19'((s_s8 + 34'd32768) >> 16);
		if (rs > 19'(OneQ14)) rs = 19'(OneQ14);
		sine = neg_s8 ? -$signed({1'b0, rs[14:0]}) : $signed({1'b0, rs[14:0]});
	end
endmodule

// ----- src/uv_sphere_mesh_generator.sv -----
// Top level of the UV-sphere mesh unit: APB register file, query decode,
// sine units and output stages. Uses usmg_pkg and usmg_sine.
`timescale 1ns / 1ps
// A query word enters on start when busy is low; busy is tied low, so one
// word may be issued in every clock cycle. Each query gives exactly one result
// word, shown on the result ports for one cycle with done high.
// Each word passes through the angle register, the eight sine stages (fold,
// square, Horner products, rounding), the azimuth product stage, the radius
// product stage and the output register.
// Throughput is one word per cycle with no exceptions.
// A vertex query gives positions, normals and texture coordinates; a triangle
// query gives three vertex indices. Faulted queries give fault and zeros.
// The user must write the registers through the APB port only while no
// query is in flight; the block does not enforce this. Reset, asynchronous
// and active low, clears the valid pipeline and loads the register defaults;
// nothing else needs clearing.
// The receiver cannot stall: a result is taken in the cycle it is shown.
module uv_sphere_mesh_generator #(
	parameter int MAX_SEGMENTS = usmg_pkg::MaxSegmentsDef,
	parameter int ANGLE_BITS = usmg_pkg::AngleBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [7:0]         ring,
	input  logic [8:0]         column,
	input  logic               half,
	output logic               done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        corner_a,
	output logic [15:0]        corner_b,
	output logic [15:0]        corner_c,
	output logic               fault
);
	import usmg_pkg::*;

	localparam int Depth = 12;
	localparam int SineLat = 8;

	// Registers.
	logic [8:0]  seg_q;
	logic [15:0] radius_q;
	logic        flip_q;
	logic [16:0] ustep_q, vstep_q;
	logic [15:0] cphase_q, rphase_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= 9'd16;
			radius_q <= 16'd256;
			flip_q <= 1'b0;
			ustep_q <= 17'd4096;
			vstep_q <= 17'd8192;
			cphase_q <= 16'd4096;
			rphase_q <= 16'd4096;
		end else if (wr_en) begin
			case (reg_idx)
				RegSegments:  seg_q <= pwdata[8:0];
				RegRadius:    radius_q <= pwdata[15:0];
				RegFlip:      flip_q <= pwdata[0];
				RegUStep:     ustep_q <= pwdata[16:0];
				RegVStep:     vstep_q <= pwdata[16:0];
				RegColPhase:  cphase_q <= pwdata[15:0];
				RegRingPhase: rphase_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegSegments:  prdata = 32'(seg_q);
			RegRadius:    prdata = 32'(radius_q);
			RegFlip:      prdata = 32'(flip_q);
			RegUStep:     prdata = 32'(ustep_q);
			RegVStep:     prdata = 32'(vstep_q);
			RegColPhase:  prdata = 32'(cphase_q);
			RegRingPhase: prdata = 32'(rphase_q);
			default:      prdata = 32'd0;
		endcase
	end

	// Stage 1: decode, angle and index products.
	logic [7:0]  vlast;
	logic        cfg_bad, bad;
	kind_t       kind;
	logic [23:0] pol_raw, az_raw;
	logic [15:0] pol16, az16;
	logic [25:0] tu_raw, tv_raw;
	logic [16:0] tu, tv;
	logic [15:0] rowbase, ra, rb, last, bot, ca, cb, cc;
	logic        vrt_wrap;

	function automatic logic [15:0] cut16(input logic [23:0] a);
		logic [23:0] m;
		m = a & 24'((64'd1 << ANGLE_BITS) - 1);
		if (ANGLE_BITS >= 16) cut16 = 16'(m >> (ANGLE_BITS - 16));
		else cut16 = 16'(m << (16 - ANGLE_BITS));
	endfunction

	always_comb begin
		vlast = seg_q[8:1];
		cfg_bad = (seg_q < 9'd4) || (32'(seg_q) > MAX_SEGMENTS) || (radius_q == 16'd0);
		kind = KIND_FAULT;
		bad = cfg_bad;
		vrt_wrap = 1'b0;
		if (action == ActVertex) begin
			if (ring > vlast) bad = 1'b1;
			else if (ring == 8'd0 || ring == vlast) begin
				if (column >= seg_q) bad = 1'b1;
				kind = KIND_POLE;
			end else begin
				if (column > seg_q) bad = 1'b1;
				vrt_wrap = (column == seg_q);
				kind = KIND_RING;
			end
		end else begin
			kind = KIND_TRI;
			if (ring > vlast - 8'd1 || column >= seg_q) bad = 1'b1;
			else if ((ring == 8'd0 || ring == vlast - 8'd1) && half) bad = 1'b1;
		end
		if (bad) kind = KIND_FAULT;
		pol_raw = 24'(ring) * 24'(rphase_q);
		az_raw = 24'(24'd1 << (ANGLE_BITS - 1)) + 24'(column) * 24'(cphase_q);
		pol16 = cut16(pol_raw);
		az16 = cut16(az_raw);
		tu_raw = 26'(column) * 26'(ustep_q);
		tv_raw = 26'(ring) * 26'(vstep_q);
		tu = (tu_raw > 26'(OneQ16)) ? OneQ16 : tu_raw[16:0];
		tv = (tv_raw > 26'(OneQ16)) ? OneQ16 : tv_raw[16:0];
		if (ring == 8'd0 && kind == KIND_POLE) tv = 17'd0;
		else if (kind == KIND_POLE) tv = OneQ16;
		if (vrt_wrap) tu = OneQ16;
		// Vertex indices for triangles.
		bot = 16'(seg_q) + 16'(vlast - 8'd1) * 16'(seg_q + 9'd1);
		last = bot - 16'(seg_q + 9'd1);
		rowbase = 16'(seg_q) + 16'(ring - 8'd1) * 16'(seg_q + 9'd1);
		ra = rowbase + 16'(column);
		rb = ra + 16'(seg_q) + 16'd1;
		if (ring == 8'd0) begin
			ca = 16'(seg_q) + 16'(column);
			cb = flip_q ? ca + 16'd1 : 16'(column);
			cc = flip_q ? 16'(column) : ca + 16'd1;
		end else if (ring == vlast - 8'd1) begin
			ca = last + 16'(column);
			cb = flip_q ? bot + 16'(column) : ca + 16'd1;
			cc = flip_q ? ca + 16'd1 : bot + 16'(column);
		end else if (!half) begin
			ca = ra;
			cb = flip_q ? rb : ra + 16'd1;
			cc = flip_q ? ra + 16'd1 : rb;
		end else begin
			ca = ra + 16'd1;
			cb = flip_q ? rb : rb + 16'd1;
			cc = flip_q ? rb + 16'd1 : rb;
		end
	end

	// Sine units: polar sin, polar cos, azimuth cos, azimuth sin.
	logic signed [15:0] sp, cp, ca_z, sa_z;
	logic [15:0] pol_s1, az_s1;
	always_ff @(posedge clk) begin
		pol_s1 <= pol16;
		az_s1 <= az16;
	end
	usmg_sine u_sp (.clk(clk), .angle(pol_s1), .sine(sp));
	usmg_sine u_cp (.clk(clk), .angle(pol_s1 + 16'd16384), .sine(cp));
	usmg_sine u_ca (.clk(clk), .angle(az_s1 + 16'd16384), .sine(ca_z));
	usmg_sine u_sa (.clk(clk), .angle(az_s1), .sine(sa_z));

	// Delay line for side data: valid, kind, wrap, texture and corners.
	logic [Depth-1:0] vld_q;
	kind_t  kind_d  [SineLat+1];
	logic   wrap_d  [SineLat+1];
	logic [16:0] tu_d [SineLat+1];
	logic [16:0] tv_d [SineLat+1];
	logic [15:0] a_d [SineLat+1];
	logic [15:0] b_d [SineLat+1];
	logic [15:0] c_d [SineLat+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Depth-2:0], start};
	end

	always_ff @(posedge clk) begin
		kind_d[0] <= kind; wrap_d[0] <= vrt_wrap; tu_d[0] <= tu; tv_d[0] <= tv;
		a_d[0] <= ca; b_d[0] <= cb; c_d[0] <= cc;
		for (int i = 1; i <= SineLat; i++) begin
			kind_d[i] <= kind_d[i-1]; wrap_d[i] <= wrap_d[i-1];
			tu_d[i] <= tu_d[i-1]; tv_d[i] <= tv_d[i-1];
			a_d[i] <= a_d[i-1]; b_d[i] <= b_d[i-1]; c_d[i] <= c_d[i-1];
		end
	end

	// Stage 10: normal products and selection.
	function automatic logic signed [15:0] rq14(input logic signed [31:0] p);
		logic signed [31:0] t;
		t = (p + 32'sd8192) >>> 14;
		rq14 = 16'(t);
	endfunction

	logic signed [31:0] px, pz;
	logic signed [15:0] nx_s10, ny_s10, nz_s10;
	kind_t kind_s10;
	logic [16:0] tu_s10, tv_s10;
	logic [15:0] a_s10, b_s10, c_s10;
	assign px = sp * ca_z;
	assign pz = sp * sa_z;

	always_ff @(posedge clk) begin
		kind_s10 <= kind_d[SineLat]; tu_s10 <= tu_d[SineLat]; tv_s10 <= tv_d[SineLat];
		a_s10 <= a_d[SineLat]; b_s10 <= b_d[SineLat]; c_s10 <= c_d[SineLat];
		if (kind_d[SineLat] == KIND_POLE) begin
			nx_s10 <= '0; nz_s10 <= '0;
			ny_s10 <= (tv_d[SineLat] == 17'd0) ? 16'sd16384 : -16'sd16384;
		end else if (wrap_d[SineLat]) begin
			nx_s10 <= -sp; ny_s10 <= cp; nz_s10 <= '0;
		end else begin
			nx_s10 <= rq14(px); ny_s10 <= cp; nz_s10 <= rq14(pz);
		end
	end

	// Stage 11: radius products.
	function automatic logic signed [16:0] rpos(input logic signed [33:0] p);
		logic signed [33:0] t;
		t = (p + 34'sd8192) >>> 14;
		rpos = 17'(t);
	endfunction

	logic signed [33:0] qx, qy, qz;
	logic signed [16:0] rad_s;
	logic signed [15:0] nx_s11, ny_s11, nz_s11;
	logic signed [33:0] qx_s11, qy_s11, qz_s11;
	kind_t kind_s11;
	logic [16:0] tu_s11, tv_s11;
	logic [15:0] a_s11, b_s11, c_s11;
	assign rad_s = $signed({1'b0, radius_q});
	assign qx = nx_s10 * rad_s;
	assign qy = ny_s10 * rad_s;
	assign qz = nz_s10 * rad_s;

	always_ff @(posedge clk) begin
		qx_s11 <= qx; qy_s11 <= qy; qz_s11 <= qz;
		nx_s11 <= nx_s10; ny_s11 <= ny_s10; nz_s11 <= nz_s10;
		kind_s11 <= kind_s10; tu_s11 <= tu_s10; tv_s11 <= tv_s10;
		a_s11 <= a_s10; b_s11 <= b_s10; c_s11 <= c_s10;
	end

	// Stage 12: output register with field zeroing.
	logic vert;
	assign vert = (kind_s11 == KIND_POLE) || (kind_s11 == KIND_RING);

	always_ff @(posedge clk) begin
		pos_x <= vert ? rpos(qx_s11) : '0;
		pos_y <= vert ? rpos(qy_s11) : '0;
		pos_z <= vert ? rpos(qz_s11) : '0;
		norm_x <= vert ? (flip_q ? -nx_s11 : nx_s11) : '0;
		norm_y <= vert ? (flip_q ? -ny_s11 : ny_s11) : '0;
		norm_z <= vert ? (flip_q ? -nz_s11 : nz_s11) : '0;
		tex_u <= vert ? tu_s11 : '0;
		tex_v <= vert ? tv_s11 : '0;
		corner_a <= (kind_s11 == KIND_TRI) ? a_s11 : '0;
		corner_b <= (kind_s11 == KIND_TRI) ? b_s11 : '0;
		corner_c <= (kind_s11 == KIND_TRI) ? c_s11 : '0;
		fault <= (kind_s11 == KIND_FAULT);
	end

	assign done = vld_q[Depth-1];
endmodule
